// ===== rtl/inwbc_pkg.sv =====
// Shared types, constants and codes of the index node write-back cache.
package inwbc_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int REC_W      = 32;
    localparam int OUT_SLOT_W = 5;

    localparam logic [OUT_SLOT_W-1:0] ROOT_SLOT = 5'd16;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_MARK   = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;
    localparam logic [1:0] MODE_LOAD   = 2'd3;

    localparam logic [2:0] K_HIT    = 3'd0;
    localparam logic [2:0] K_FILL   = 3'd1;
    localparam logic [2:0] K_WBSLOT = 3'd2;
    localparam logic [2:0] K_WBROOT = 3'd3;
    localparam logic [2:0] K_ACK    = 3'd4;

    typedef struct packed {
        logic [1:0]       mode;
        logic [REC_W-1:0] record;
    } in_word_t;

    typedef struct packed {
        logic [2:0]            kind;
        logic [OUT_SLOT_W-1:0] slot;
        logic [REC_W-1:0]      tag;
        logic                  last;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic clear;
        logic mark;
    } cell_ctrl_t;

endpackage

// ===== rtl/index_node_write_back_cache.sv =====
// Top level of the index node write-back cache tag manager.
// A command word (mode, record) is taken at a rising edge with start high and busy low.
// Every result word appears on result for exactly one cycle with strobe high; the
// receiver cannot stall it. The final word of a command carries last.
// Lookups compare the record against all used slots at once: a hit, a fill of the
// next free slot, a dirty mark or a root load gives its single word in the cycle
// after acceptance, and a new command may be given in that same cycle.
// A miss on a full cache, or a flush command, writes back the dirty root in the
// cycle after acceptance, then shifts the slot chain toward slot 0 once a cycle,
// once per used slot, giving a write back word for each dirty slot. A last step
// gives the fill or acknowledge word, empties the cache and unloads the root; a
// miss then holds its record in slot 0. busy stays high through these steps and
// drops as the final word is shown.
// Reset empties the cache, clears every dirty bit and unloads the root; tags of
// slots are not cleared, as only used slots are ever compared.
module index_node_write_back_cache (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  inwbc_pkg::in_word_t   item,
    output logic                  strobe,
    output inwbc_pkg::out_word_t  result
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    localparam int SC  = inwbc_pkg::SLOT_COUNT;
    localparam int SW  = inwbc_pkg::SLOT_W;
    localparam int CW  = inwbc_pkg::CNT_W;
    localparam int RW  = inwbc_pkg::REC_W;
    localparam int OSW = inwbc_pkg::OUT_SLOT_W;

    logic                  state_reg, state_next;
    logic [CW-1:0]         used_reg, used_next;
    logic [CW-1:0]         walk_reg, walk_next;
    logic [RW-1:0]         root_value_reg, root_value_next;
    logic                  root_dirty_reg, root_dirty_next;
    logic                  fill_pend_reg, fill_pend_next;
    logic [RW-1:0]         pend_rec_reg, pend_rec_next;
    logic                  out_valid_reg, out_valid_next;
    inwbc_pkg::out_word_t  out_reg, out_next;

    logic                  accept;
    logic [RW-1:0]         key;
    logic [SC-1:0]         match_vec;
    logic [SC-1:0]         first_vec;
    logic                  hit;
    logic [SW-1:0]         hit_idx;
    logic                  full;
    logic                  walk_done;

    logic                  load_en, shift_en, clear_en, mark_en;
    logic [SW-1:0]         load_idx;
    logic [RW-1:0]         load_tag;

    logic [RW-1:0]         tag_arr   [SC];
    logic                  dirty_arr [SC];

    assign accept    = start && !busy;
    assign key       = item.record;
    assign first_vec = match_vec & (~match_vec + SC'(1));
    assign hit       = |match_vec;
    assign full      = (used_reg >= CW'(SC));
    assign walk_done = (walk_reg == used_reg);

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < SC; i++)
        begin
            if (first_vec[i])
            begin
                hit_idx = hit_idx | SW'(i);
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < SC; gi++)
        begin : g_cell
            inwbc_pkg::cell_ctrl_t cctrl;
            logic [RW-1:0]         nb_tag;
            logic                  nb_dirty;

            assign cctrl.load  = load_en && (load_idx == SW'(gi));
            assign cctrl.shift = shift_en;
            assign cctrl.clear = clear_en;
            assign cctrl.mark  = mark_en && first_vec[gi];

            if (gi == SC - 1)
            begin : g_tail
                assign nb_tag   = '0;
                assign nb_dirty = 1'b0;
            end
            else
            begin : g_body
                assign nb_tag   = tag_arr[gi+1];
                assign nb_dirty = dirty_arr[gi+1];
            end

            inwbc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cctrl),
                .valid    (CW'(gi) < used_reg),
                .key      (key),
                .load_tag (load_tag),
                .nb_tag   (nb_tag),
                .nb_dirty (nb_dirty),
                .tag      (tag_arr[gi]),
                .dirty    (dirty_arr[gi]),
                .match    (match_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        walk_next       = walk_reg;
        root_value_next = root_value_reg;
        root_dirty_next = root_dirty_reg;
        fill_pend_next  = fill_pend_reg;
        pend_rec_next   = pend_rec_reg;
        out_valid_next  = 1'b0;
        out_next        = out_reg;
        load_en         = 1'b0;
        shift_en        = 1'b0;
        clear_en        = 1'b0;
        mark_en         = 1'b0;
        load_idx        = used_reg[SW-1:0];
        load_tag        = key;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    out_next.last  = 1'b1;
                    out_next.tag   = key;
                    case (item.mode)
                        inwbc_pkg::MODE_LOOKUP:
                        begin
                            if (key == '0)
                            begin
                                out_next.slot = inwbc_pkg::ROOT_SLOT;
                                out_next.tag  = root_value_reg;
                                out_next.kind = (root_value_reg != '0) ?
                                                inwbc_pkg::K_HIT : inwbc_pkg::K_FILL;
                            end
                            else if (hit)
                            begin
                                out_next.kind = inwbc_pkg::K_HIT;
                                out_next.slot = OSW'(hit_idx);
                            end
                            else if (!full)
                            begin
                                load_en       = 1'b1;
                                used_next     = used_reg + CW'(1);
                                out_next.kind = inwbc_pkg::K_FILL;
                                out_next.slot = OSW'(used_reg);
                            end
                            else
                            begin
                                fill_pend_next = 1'b1;
                                pend_rec_next  = key;
                                walk_next      = '0;
                                state_next     = ST_FLUSH;
                                out_valid_next = root_dirty_reg;
                                out_next.kind  = inwbc_pkg::K_WBROOT;
                                out_next.slot  = inwbc_pkg::ROOT_SLOT;
                                out_next.tag   = root_value_reg;
                                out_next.last  = 1'b0;
                            end
                        end
                        inwbc_pkg::MODE_MARK:
                        begin
                            out_next.kind = inwbc_pkg::K_ACK;
                            if (key == '0)
                            begin
                                if (root_value_reg != '0)
                                begin
                                    root_dirty_next = 1'b1;
                                end
                                out_next.slot = inwbc_pkg::ROOT_SLOT;
                            end
                            else if (hit)
                            begin
                                mark_en       = 1'b1;
                                out_next.slot = OSW'(hit_idx);
                            end
                            else
                            begin
                                out_next.slot = '0;
                            end
                        end
                        inwbc_pkg::MODE_FLUSH:
                        begin
                            fill_pend_next = 1'b0;
                            pend_rec_next  = key;
                            walk_next      = '0;
                            state_next     = ST_FLUSH;
                            out_valid_next = root_dirty_reg;
                            out_next.kind  = inwbc_pkg::K_WBROOT;
                            out_next.slot  = inwbc_pkg::ROOT_SLOT;
                            out_next.tag   = root_value_reg;
                            out_next.last  = 1'b0;
                        end
                        default:
                        begin
                            root_value_next = key;
                            root_dirty_next = 1'b0;
                            out_next.kind   = inwbc_pkg::K_ACK;
                            out_next.slot   = inwbc_pkg::ROOT_SLOT;
                        end
                    endcase
                end
            end
            ST_FLUSH:
            begin
                if (walk_done)
                begin
                    clear_en        = 1'b1;
                    root_value_next = '0;
                    root_dirty_next = 1'b0;
                    state_next      = ST_IDLE;
                    out_valid_next  = 1'b1;
                    out_next.slot   = '0;
                    out_next.last   = 1'b1;
                    if (fill_pend_reg)
                    begin
                        load_en       = 1'b1;
                        load_idx      = '0;
                        load_tag      = pend_rec_reg;
                        used_next     = CW'(1);
                        out_next.kind = inwbc_pkg::K_FILL;
                        out_next.tag  = pend_rec_reg;
                    end
                    else
                    begin
                        used_next     = '0;
                        out_next.kind = inwbc_pkg::K_ACK;
                        out_next.tag  = '0;
                    end
                end
                else
                begin
                    shift_en       = 1'b1;
                    walk_next      = walk_reg + CW'(1);
                    out_valid_next = dirty_arr[0];
                    out_next.kind  = inwbc_pkg::K_WBSLOT;
                    out_next.slot  = OSW'(walk_reg);
                    out_next.tag   = tag_arr[0];
                    out_next.last  = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            walk_reg       <= '0;
            root_value_reg <= '0;
            root_dirty_reg <= 1'b0;
            fill_pend_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            walk_reg       <= walk_next;
            root_value_reg <= root_value_next;
            root_dirty_reg <= root_dirty_next;
            fill_pend_reg  <= fill_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_rec_reg <= pend_rec_next;
        out_reg      <= out_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = out_valid_reg;
    assign result = out_reg;

endmodule

// ===== rtl/inwbc_cell.sv =====
// One cache slot: tag, dirty bit and tag compare, shifting toward slot 0.
module inwbc_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  inwbc_pkg::cell_ctrl_t          ctrl,
    input  logic                           valid,
    input  logic [inwbc_pkg::REC_W-1:0]    key,
    input  logic [inwbc_pkg::REC_W-1:0]    load_tag,
    input  logic [inwbc_pkg::REC_W-1:0]    nb_tag,
    input  logic                           nb_dirty,
    output logic [inwbc_pkg::REC_W-1:0]    tag,
    output logic                           dirty,
    output logic                           match
);

    logic [inwbc_pkg::REC_W-1:0] tag_reg;
    logic                        dirty_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            tag_reg <= load_tag;
        end
        else if (ctrl.shift)
        begin
            tag_reg <= nb_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            dirty_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            dirty_reg <= nb_dirty;
        end
        else if (ctrl.clear)
        begin
            dirty_reg <= 1'b0;
        end
        else if (ctrl.mark)
        begin
            dirty_reg <= 1'b1;
        end
    end

    assign tag   = tag_reg;
    assign dirty = dirty_reg;
    assign match = valid && (tag_reg == key);

endmodule

// ===== rtl/inwbc_checker.sv =====
// Port-level checks of the index node write-back cache, bound to the top level.
module inwbc_props (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input inwbc_pkg::in_word_t   item,
    input logic                  strobe,
    input inwbc_pkg::out_word_t  result
);

    // A dirty mark or a root load answers with one final word in the next cycle.
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.mode == inwbc_pkg::MODE_MARK ||
                           item.mode == inwbc_pkg::MODE_LOAD)
        |=> strobe && result.last && result.kind == inwbc_pkg::K_ACK &&
            result.tag == $past(item.record))
        else $error("mark or load not acknowledged in the next cycle");

    // The final word of a command frees the block for the next one.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last |-> !busy)
        else $error("busy while the final word is shown");

    // Write back words only come while a flush is running.
    a_wb_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> busy &&
            (result.kind == inwbc_pkg::K_WBSLOT || result.kind == inwbc_pkg::K_WBROOT))
        else $error("intermediate word outside a flush");

    // A root write back names the root entry and never ends a command.
    a_wb_root: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.kind == inwbc_pkg::K_WBROOT
        |-> result.slot == inwbc_pkg::ROOT_SLOT && !result.last)
        else $error("malformed root write back");

endmodule

bind index_node_write_back_cache inwbc_props u_inwbc_props (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
);
